/* rtl/u8u16_pkg.sv */
// Constants shared by the UTF-8 to 16-bit code unit decoder.
package u8u16_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned ACC_W   = 21;
    localparam int unsigned COUNT_W = 16;

    // Saturation point of the output byte count and the step per unit
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFE;
    localparam logic [COUNT_W-1:0] COUNT_STEP = 16'd2;

    // Code point dropped while no unit has been emitted since reset or the last terminator
    localparam logic [ACC_W-1:0] CODE_SPACE = 21'h000020;

    // Lead byte classes
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    function automatic t_lead classify_lead(input logic [BYTE_W-1:0] b);
        t_lead cls;
        if (b[7] == 1'b0) begin
            cls = LEAD_ASCII;
        end else if (b[7:5] == 3'b110) begin
            cls = LEAD_TWO;
        end else if (b[7:4] == 4'b1110) begin
            cls = LEAD_THREE;
        end else if (b[7:4] == 4'b1111) begin
            cls = LEAD_FOUR;
        end else begin
            cls = LEAD_BAD;
        end
        return cls;
    endfunction

endpackage

/* rtl/utf8_to_utf16_stream_decoder.sv */
// Top level: UTF-8 byte stream to 16-bit code unit decoder.
// An accepted byte beat is held in the input register, then its result in the output register.
// Throughput: one byte per cycle; a byte that yields a unit stalls while the result waits.
// Each byte is handled in one pass through the decode logic between the two registers.
// Reset (synchronous, active low) empties both stages and clears the decode state.
module utf8_to_utf16_stream_decoder
    import u8u16_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BYTE_W-1:0]  i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [UNIT_W-1:0]  o_code_unit,
    output logic [COUNT_W-1:0] o_byte_count,
    output logic               o_last,
    output logic               o_malformed
);

    // Input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Decode state
    logic [1:0]         r_remaining, n_remaining;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_discard, n_discard;

    // Output stage
    logic               r_out_valid;
    logic [UNIT_W-1:0]  r_out_unit, n_out_unit;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_last, n_out_last;
    logic               r_out_bad, n_out_bad;

    logic               emit;
    logic               advance;
    logic               done;
    logic [ACC_W-1:0]   code;
    logic [ACC_W-1:0]   shifted;
    t_lead              lead;

    assign lead    = classify_lead(r_in_byte);
    assign shifted = {r_acc[ACC_W-7:0], r_in_byte[5:0]};

    // Decode one byte against the current state
    always_comb begin
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_count     = r_count;
        n_discard   = r_discard;
        n_out_unit  = '0;
        n_out_count = r_count;
        n_out_last  = 1'b0;
        n_out_bad   = 1'b0;
        emit        = 1'b0;
        done        = 1'b0;
        code        = '0;

        if (r_in_byte == '0) begin
            // terminator: report and return to the start state
            emit        = 1'b1;
            n_out_last  = 1'b1;
            n_out_bad   = r_discard | (r_remaining != 2'd0);
            n_remaining = '0;
            n_acc       = '0;
            n_count     = '0;
            n_discard   = 1'b0;
        end else if (!r_discard) begin
            if (r_remaining == 2'd0) begin
                unique case (lead)
                    LEAD_ASCII: begin
                        code = {{(ACC_W-BYTE_W){1'b0}}, r_in_byte};
                        done = 1'b1;
                    end
                    LEAD_TWO: begin
                        n_acc       = {{(ACC_W-5){1'b0}}, r_in_byte[4:0]};
                        n_remaining = 2'd1;
                    end
                    LEAD_THREE: begin
                        n_acc       = {{(ACC_W-4){1'b0}}, r_in_byte[3:0]};
                        n_remaining = 2'd2;
                    end
                    LEAD_FOUR: begin
                        n_acc       = {{(ACC_W-3){1'b0}}, r_in_byte[2:0]};
                        n_remaining = 2'd3;
                    end
                    default: begin
                        n_discard = 1'b1;
                    end
                endcase
            end else if (r_in_byte[7:6] != 2'b10) begin
                // broken sequence
                n_discard   = 1'b1;
                n_remaining = '0;
                n_acc       = '0;
            end else begin
                n_remaining = r_remaining - 2'd1;
                if (r_remaining == 2'd1) begin
                    code  = shifted;
                    n_acc = '0;
                    done  = 1'b1;
                end else begin
                    n_acc = shifted;
                end
            end

            // leading spaces are dropped
            if (done && !(r_count == '0 && code == CODE_SPACE)) begin
                emit        = 1'b1;
                n_count     = (r_count >= COUNT_MAX - COUNT_STEP) ? COUNT_MAX
                                                                  : r_count + COUNT_STEP;
                n_out_unit  = code[UNIT_W-1:0];
                n_out_count = n_count;
            end
        end
    end

    // Stage moves when its byte yields nothing or the output slot frees up
    assign advance = r_in_valid && (!emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_remaining <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_discard   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_remaining <= n_remaining;
                r_acc       <= n_acc;
                r_count     <= n_count;
                r_discard   <= n_discard;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance && emit) begin
            r_out_unit  <= n_out_unit;
            r_out_count <= n_out_count;
            r_out_last  <= n_out_last;
            r_out_bad   <= n_out_bad;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_unit  = r_out_unit;
    assign o_byte_count = r_out_count;
    assign o_last       = r_out_last;
    assign o_malformed  = r_out_bad;

endmodule
